// File: rtl/assert_macros.svh
// Assertion macros used by the checker file sbb_check.sv.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SBB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define SBB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/sbb_pkg.sv
// Package of the separable box blur: sizes, codes, payload structs, states.
// Depends on nothing.
package sbb_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 2048;
	localparam int MAX_RADIUS = 12;

	localparam int WIN_LEN   = 2 * MAX_RADIUS + 1;
	localparam int RING_ROWS = 2 * MAX_RADIUS + 2;

	localparam int CFG_W     = 12;
	localparam int CFG_R_W   = 4;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int W_DIM_W   = $clog2(MAX_WIDTH + 1);
	localparam int H_DIM_W   = $clog2(MAX_HEIGHT + 1);
	localparam int XW        = ((W_DIM_W > H_DIM_W) ? W_DIM_W : H_DIM_W) + 1;
	localparam int RAD_W     = $clog2(MAX_RADIUS + 1);
	localparam int WIN_W     = $clog2(WIN_LEN);
	localparam int RING_W    = $clog2(RING_ROWS);
	localparam int SUM_W     = $clog2(WIN_LEN * 255 + 1);
	localparam int CNT_W     = $clog2(WIN_LEN + 1);
	localparam int MEM_DEPTH = RING_ROWS * MAX_WIDTH;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);

	localparam logic [CFG_W-1:0]   WIDTH_RST  = CFG_W'(1920);
	localparam logic [CFG_W-1:0]   HEIGHT_RST = CFG_W'(1080);
	localparam logic [CFG_R_W-1:0] RADIUS_RST = CFG_R_W'(12);

	typedef enum logic [1:0] {
		REG_WIDTH,
		REG_HEIGHT,
		REG_RADIUS
	} reg_idx_t;

	typedef enum logic {
		OP_PIXEL,
		OP_DRAIN
	} op_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	typedef struct packed {
		logic [SUM_W-1:0] r;
		logic [SUM_W-1:0] g;
		logic [SUM_W-1:0] b;
	} sum3_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_HSET,
		S_HSUM,
		S_DIVGO,
		S_DIVWT,
		S_HWR,
		S_VSET,
		S_VRD,
		S_VLAST,
		S_VOUT
	} state_t;

endpackage

// File: rtl/sbb_ram.sv
// Simple dual-port RAM, one write and one registered read per cycle.
// Depends on nothing.
module sbb_ram #(
	parameter int DATA_W = 24,
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// File: rtl/sbb_div.sv
// Restoring divider: three channel sums by one window count, one bit a cycle.
// Depends on sbb_pkg.
module sbb_div import sbb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  sum3_t            num,
	input  logic [CNT_W-1:0] den,
	output logic             done,
	output rgb_t             quo
);

	localparam int IT_W = $clog2(SUM_W + 1);

	sum3_t                num_q;
	logic [CNT_W:0]       rem_r_q, rem_g_q, rem_b_q;
	logic [CNT_W-1:0]     den_q;
	logic [IT_W-1:0]      it_q;
	logic                 busy_q, done_q;

	// One restoring step: returns {remainder, quotient bit}.
	function automatic logic [CNT_W+1:0] step(input logic [CNT_W:0] rem,
			input logic nb, input logic [CNT_W-1:0] d);
		logic [CNT_W+1:0] trial;
		trial = {rem, nb};
		if (trial >= (CNT_W+2)'(d)) begin
			return {(CNT_W+1)'(trial - (CNT_W+2)'(d)), 1'b1};
		end
		return {trial[CNT_W:0], 1'b0};
	endfunction

	logic [CNT_W+1:0] sr, sg, sb;

	always_comb begin
		sr = step(rem_r_q, num_q.r[SUM_W-1], den_q);
		sg = step(rem_g_q, num_q.g[SUM_W-1], den_q);
		sb = step(rem_b_q, num_q.b[SUM_W-1], den_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			it_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				it_q   <= IT_W'(SUM_W);
			end else if (busy_q) begin
				it_q <= it_q - 1'b1;
				if (it_q == IT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q   <= num;
			den_q   <= den;
			rem_r_q <= '0;
			rem_g_q <= '0;
			rem_b_q <= '0;
		end else if (busy_q) begin
			// Shift quotient bits in from the bottom.
			num_q.r <= {num_q.r[SUM_W-2:0], sr[0]};
			num_q.g <= {num_q.g[SUM_W-2:0], sg[0]};
			num_q.b <= {num_q.b[SUM_W-2:0], sb[0]};
			rem_r_q <= sr[CNT_W+1:1];
			rem_g_q <= sg[CNT_W+1:1];
			rem_b_q <= sb[CNT_W+1:1];
		end
	end

	assign done  = done_q;
	assign quo.r = num_q.r[7:0];
	assign quo.g = num_q.g[7:0];
	assign quo.b = num_q.b[7:0];

endmodule

// File: rtl/separable_box_blur.sv
// Separable box blur over an RGB raster stream. Each in-frame pixel writes the
// raw row window (2*MAX_RADIUS+1 entries in flops); once x >= R it forms the
// horizontal average of column x-R (at row end also of the last R columns) by
// walking the window one pixel a cycle, divides by the in-frame count in a
// shared restoring divider, and writes the byte triple into a line store RAM
// of 2*MAX_RADIUS+2 rows. Once R+1 rows are buffered a pixel also produces
// output pixel (x, y-R-1): the in-frame rows of that column are read from the
// RAM one a cycle (registered read), summed and divided likewise. Drain items
// (operation 1) emit the last R+1 rows one pixel each; the final pixel carries
// frame_last. Each horizontal column and each vertical output sums a window of
// n entries, n being the window count (at most 2*R+1), and then waits for the
// divider; the input is stalled until the item is done. The configuration is
// sampled when the first pixel of a frame arrives; width and height saturate
// to 1..MAX, the radius to MAX_RADIUS. Pixels past the frame end and early
// drains are taken and dropped. The output register lets a new item be accepted
// while a result waits for transfer. The line store needs no clearing: every
// entry is written before it is read.
module separable_box_blur import sbb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	// configuration write port
	input  logic             wr_en,
	input  logic [1:0]       wr_index,
	input  logic [CFG_W-1:0] wr_data,
	// input channel
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             operation,
	input  logic [7:0]       red_in,
	input  logic [7:0]       green_in,
	input  logic [7:0]       blue_in,
	// output channel
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       red_out,
	output logic [7:0]       green_out,
	output logic [7:0]       blue_out,
	output logic             frame_last
);

	// Configuration registers
	logic [CFG_W-1:0]   cfg_w_q, cfg_h_q;
	logic [CFG_R_W-1:0] cfg_r_q;

	// Per-frame latched configuration
	logic               active_q;
	logic [W_DIM_W-1:0] lat_w_q;
	logic [H_DIM_W-1:0] lat_h_q;
	logic [RAD_W-1:0]   lat_r_q;

	// Stream position counters
	logic [COL_W-1:0]   in_col_q, out_col_q;
	logic [H_DIM_W-1:0] in_row_q, out_row_q;
	logic [WIN_W-1:0]   raw_slot_q;
	logic [RING_W-1:0]  row_slot_q, out_slot_q;

	rgb_t               raw_win_q [WIN_LEN];

	// Job registers of the item at work
	state_t             state_q, state_d;
	logic [COL_W-1:0]   job_x_q, job_col_q, job_ce_q;
	logic [WIN_W-1:0]   job_rslot_q;
	logic [RING_W-1:0]  job_yslot_q;
	logic               job_emit_q, job_last_q, is_v_q;
	sum3_t              acc_q;
	logic [CNT_W-1:0]   left_q, cnt_q;
	logic [WIN_W-1:0]   rptr_q;
	logic [RING_W-1:0]  vslot_q;
	logic               rd_v_q;

	// Output register
	logic               out_valid_q, out_last_q;
	rgb_t               out_pix_q;

	// Control outputs of the sequencer
	logic               accept, div_start, mem_we, out_load;

	// Divider and RAM
	logic               div_done;
	rgb_t               div_quo;
	logic [ADDR_W-1:0]  wr_addr, rd_addr;
	rgb_t               rd_data;

	// ------------------------------------------------------------------
	// Accept-time decode: use live config when a pixel opens a new frame.
	// ------------------------------------------------------------------
	logic [W_DIM_W-1:0] eff_w;
	logic [H_DIM_W-1:0] eff_h;
	logic [RAD_W-1:0]   eff_r;
	logic [COL_W-1:0]   cur_col, cur_ocol;
	logic [H_DIM_W-1:0] cur_row, cur_orow;
	logic [WIN_W-1:0]   cur_rslot;
	logic [RING_W-1:0]  cur_yslot, cur_oslot;
	logic [XW-1:0]      x_ext, r_ext;
	logic               end_row, x_ge_r, h_on, emit, pix_take, drain_take, drain_last;
	logic [COL_W-1:0]   cs, ce;
	logic               is_pix, new_frame;

	always_comb begin
		is_pix    = (operation == OP_PIXEL);
		new_frame = is_pix && !active_q;
		if (active_q) begin
			eff_w = lat_w_q;
			eff_h = lat_h_q;
			eff_r = lat_r_q;
		end else begin
			eff_w = (cfg_w_q == '0) ? W_DIM_W'(1) :
				((32'(cfg_w_q) > MAX_WIDTH) ? W_DIM_W'(MAX_WIDTH) : W_DIM_W'(cfg_w_q));
			eff_h = (cfg_h_q == '0) ? H_DIM_W'(1) :
				((32'(cfg_h_q) > MAX_HEIGHT) ? H_DIM_W'(MAX_HEIGHT) : H_DIM_W'(cfg_h_q));
			eff_r = (32'(cfg_r_q) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : RAD_W'(cfg_r_q);
		end
		cur_col   = active_q ? in_col_q   : '0;
		cur_row   = active_q ? in_row_q   : '0;
		cur_rslot = active_q ? raw_slot_q : '0;
		cur_yslot = active_q ? row_slot_q : '0;
		cur_ocol  = active_q ? out_col_q  : '0;
		cur_orow  = active_q ? out_row_q  : '0;
		cur_oslot = active_q ? out_slot_q : '0;

		x_ext    = XW'(cur_col);
		r_ext    = XW'(eff_r);
		end_row  = (x_ext + XW'(1)) >= XW'(eff_w);
		x_ge_r   = x_ext >= r_ext;
		h_on     = x_ge_r || end_row;
		cs       = x_ge_r ? COL_W'(x_ext - r_ext) : '0;
		ce       = end_row ? COL_W'(XW'(eff_w) - XW'(1)) : cs;
		emit     = (XW'(cur_orow) + r_ext + XW'(1)) <= XW'(cur_row);
		pix_take = is_pix && (XW'(cur_row) < XW'(eff_h));

		drain_take = !is_pix && active_q && (in_row_q >= lat_h_q) && (out_row_q < lat_h_q);
		drain_last = ((XW'(out_col_q) + XW'(1)) >= XW'(lat_w_q)) &&
			((XW'(out_row_q) + XW'(1)) >= XW'(lat_h_q));
	end

	// ------------------------------------------------------------------
	// Window setup for the horizontal column and the vertical output.
	// ------------------------------------------------------------------
	logic [XW-1:0]     h_lo, v_o, v_lo, v_hi, lr_ext;
	logic [CNT_W-1:0]  h_cnt, v_cnt;
	logic [RING_W-1:0] v_d, v_start;

	always_comb begin
		lr_ext = XW'(lat_r_q);
		h_lo   = (XW'(job_col_q) > lr_ext) ? XW'(job_col_q) - lr_ext : '0;
		h_cnt  = CNT_W'(XW'(job_x_q) - h_lo + XW'(1));
		v_o    = XW'(out_row_q);
		v_lo   = (v_o > lr_ext) ? v_o - lr_ext : '0;
		v_hi   = ((v_o + lr_ext) > (XW'(lat_h_q) - XW'(1))) ?
			(XW'(lat_h_q) - XW'(1)) : (v_o + lr_ext);
		v_cnt  = CNT_W'(v_hi - v_lo + XW'(1));
		v_d    = RING_W'(v_o - v_lo);
		// Ring slot of the top window row, wrapped over the ring depth.
		v_start = (out_slot_q >= v_d) ? (out_slot_q - v_d) :
			(out_slot_q + RING_W'(RING_ROWS) - v_d);
	end

	// ------------------------------------------------------------------
	// Sequencer: next state
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					priority if (pix_take && h_on) begin
						state_d = S_HSET;
					end else if (pix_take && emit) begin
						state_d = S_VSET;
					end else if (drain_take) begin
						state_d = S_VSET;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_HSET:  state_d = S_HSUM;
			S_HSUM:  state_d = (left_q == CNT_W'(1)) ? S_DIVGO : S_HSUM;
			S_DIVGO: state_d = S_DIVWT;
			S_DIVWT: begin
				if (div_done) begin
					state_d = is_v_q ? S_VOUT : S_HWR;
				end
			end
			S_HWR: begin
				if (job_col_q != job_ce_q) begin
					state_d = S_HSET;
				end else begin
					state_d = job_emit_q ? S_VSET : S_IDLE;
				end
			end
			S_VSET:  state_d = S_VRD;
			S_VRD:   state_d = (left_q == CNT_W'(1)) ? S_VLAST : S_VRD;
			S_VLAST: state_d = S_DIVGO;
			S_VOUT: begin
				if (!out_valid_q || !out_stall) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencer: control outputs
	// ------------------------------------------------------------------
	always_comb begin
		in_stall  = (state_q != S_IDLE);
		accept    = in_valid && (state_q == S_IDLE);
		div_start = (state_q == S_DIVGO);
		mem_we    = (state_q == S_HWR);
		out_load  = (state_q == S_VOUT) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w_q <= WIDTH_RST;
			cfg_h_q <= HEIGHT_RST;
			cfg_r_q <= RADIUS_RST;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_WIDTH:  cfg_w_q <= wr_data;
				REG_HEIGHT: cfg_h_q <= wr_data;
				REG_RADIUS: cfg_r_q <= wr_data[CFG_R_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Frame and position counters
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= 1'b0;
			lat_w_q    <= W_DIM_W'(1);
			lat_h_q    <= H_DIM_W'(1);
			lat_r_q    <= '0;
			in_col_q   <= '0;
			in_row_q   <= '0;
			raw_slot_q <= '0;
			row_slot_q <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_slot_q <= '0;
		end else if (accept) begin
			if (new_frame) begin
				active_q   <= 1'b1;
				lat_w_q    <= eff_w;
				lat_h_q    <= eff_h;
				lat_r_q    <= eff_r;
				out_col_q  <= cur_ocol;
				out_row_q  <= cur_orow;
				out_slot_q <= cur_oslot;
			end
			if (pix_take) begin
				raw_slot_q <= (cur_rslot == WIN_W'(WIN_LEN - 1)) ? '0 : cur_rslot + 1'b1;
				if (end_row) begin
					in_col_q   <= '0;
					in_row_q   <= cur_row + 1'b1;
					row_slot_q <= (cur_yslot == RING_W'(RING_ROWS - 1)) ? '0 :
						cur_yslot + 1'b1;
				end else begin
					in_col_q   <= cur_col + 1'b1;
					in_row_q   <= cur_row;
					row_slot_q <= cur_yslot;
				end
			end
		end else if (out_load) begin
			// Advance the output position; close the frame after the last pixel.
			if (job_last_q) begin
				active_q   <= 1'b0;
				in_col_q   <= '0;
				in_row_q   <= '0;
				raw_slot_q <= '0;
				row_slot_q <= '0;
				out_col_q  <= '0;
				out_row_q  <= '0;
				out_slot_q <= '0;
			end else if ((XW'(out_col_q) + XW'(1)) >= XW'(lat_w_q)) begin
				out_col_q  <= '0;
				out_row_q  <= out_row_q + 1'b1;
				out_slot_q <= (out_slot_q == RING_W'(RING_ROWS - 1)) ? '0 :
					out_slot_q + 1'b1;
			end else begin
				out_col_q <= out_col_q + 1'b1;
			end
		end
	end

	// Raw window write
	always_ff @(posedge clk) begin
		if (accept && pix_take) begin
			raw_win_q[cur_rslot] <= '{r: red_in, g: green_in, b: blue_in};
		end
	end

	// ------------------------------------------------------------------
	// Job datapath
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_q <= 1'b0;
		end else begin
			rd_v_q <= (state_q == S_VRD);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			job_x_q     <= cur_col;
			job_col_q   <= cs;
			job_ce_q    <= ce;
			job_rslot_q <= cur_rslot;
			job_yslot_q <= cur_yslot;
			job_emit_q  <= emit;
			job_last_q  <= drain_take && drain_last;
		end
		unique case (state_q)
			S_HSET: begin
				left_q <= h_cnt;
				cnt_q  <= h_cnt;
				rptr_q <= job_rslot_q;
				acc_q  <= '0;
				is_v_q <= 1'b0;
			end
			S_HSUM: begin
				acc_q.r <= acc_q.r + SUM_W'(raw_win_q[rptr_q].r);
				acc_q.g <= acc_q.g + SUM_W'(raw_win_q[rptr_q].g);
				acc_q.b <= acc_q.b + SUM_W'(raw_win_q[rptr_q].b);
				rptr_q  <= (rptr_q == '0) ? WIN_W'(WIN_LEN - 1) : rptr_q - 1'b1;
				left_q  <= left_q - 1'b1;
			end
			S_HWR: begin
				job_col_q <= job_col_q + 1'b1;
			end
			S_VSET: begin
				left_q  <= v_cnt;
				cnt_q   <= v_cnt;
				vslot_q <= v_start;
				acc_q   <= '0;
				is_v_q  <= 1'b1;
			end
			S_VRD: begin
				vslot_q <= (vslot_q == RING_W'(RING_ROWS - 1)) ? '0 : vslot_q + 1'b1;
				left_q  <= left_q - 1'b1;
			end
			default: ;
		endcase
		// Sum RAM data in the cycle after each read.
		if (rd_v_q) begin
			acc_q.r <= acc_q.r + SUM_W'(rd_data.r);
			acc_q.g <= acc_q.g + SUM_W'(rd_data.g);
			acc_q.b <= acc_q.b + SUM_W'(rd_data.b);
		end
	end

	assign wr_addr = ADDR_W'(job_yslot_q) * ADDR_W'(MAX_WIDTH) + ADDR_W'(job_col_q);
	assign rd_addr = ADDR_W'(vslot_q) * ADDR_W'(MAX_WIDTH) + ADDR_W'(out_col_q);

	sbb_ram #(
		.DATA_W ($bits(rgb_t)),
		.DEPTH  (MEM_DEPTH),
		.ADDR_W (ADDR_W)
	) u_line_store (
		.clk     (clk),
		.we      (mem_we),
		.wr_addr (wr_addr),
		.wr_data (div_quo),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	sbb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (acc_q),
		.den    (cnt_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	// ------------------------------------------------------------------
	// Output register: hold until transfer, reload from the divider.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_pix_q  <= div_quo;
			out_last_q <= job_last_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign red_out    = out_pix_q.r;
	assign green_out  = out_pix_q.g;
	assign blue_out   = out_pix_q.b;
	assign frame_last = out_last_q;

endmodule

// File: rtl/sbb_check.sv
// Port-level checker of the separable box blur, bound to the top level.
// Depends on sbb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sbb_check import sbb_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             wr_en,
	input logic [1:0]       wr_index,
	input logic [CFG_W-1:0] wr_data,
	input logic             in_valid,
	input logic             in_stall,
	input logic             operation,
	input logic [7:0]       red_in,
	input logic [7:0]       green_in,
	input logic [7:0]       blue_in,
	input logic             out_valid,
	input logic             out_stall,
	input logic [7:0]       red_out,
	input logic [7:0]       green_out,
	input logic [7:0]       blue_out,
	input logic             frame_last
);

	// A stalled result stays offered.
	`SBB_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid, "result dropped while stalled")

	// A stalled result does not change.
	`SBB_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(red_out) && $stable(green_out) && $stable(blue_out) && $stable(frame_last), "stalled result changed")

	// A new result only appears right after the input was held.
	`SBB_ASSERT_NOW(a_rise_busy, clk, arst_n, $rose(out_valid), $past(in_stall), "result without work cycle")

	// A result loaded at a transfer leaves the block ready for input.
	`SBB_ASSERT_NEXT(a_reload_ready, clk, arst_n, out_valid && !out_stall, !out_valid || !in_stall, "reload left input stalled")

endmodule

bind separable_box_blur sbb_check u_sbb_check (.*);

// File: sim/tb.sv
// Self-checking testbench of separable_box_blur: random and directed frames with drain items.
// Depends on sbb_pkg and the separable_box_blur RTL; predicts every output pixel itself.
module tb;
	import sbb_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		op_t  op;
		rgb_t px;
	} blur_item_t;

	typedef struct {
		rgb_t px;
		logic last;
	} blur_pixel_t;

	logic             clk;
	logic             arst_n;
	logic             wr_en;
	logic [1:0]       wr_index;
	logic [CFG_W-1:0] wr_data;
	logic             in_valid;
	logic             in_stall;
	logic             operation;
	logic [7:0]       red_in, green_in, blue_in;
	logic             out_valid;
	logic             out_stall;
	logic [7:0]       red_out, green_out, blue_out;
	logic             frame_last;

	separable_box_blur DUT (
		.clk(clk), .arst_n(arst_n),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.in_valid(in_valid), .in_stall(in_stall), .operation(operation),
		.red_in(red_in), .green_in(green_in), .blue_in(blue_in),
		.out_valid(out_valid), .out_stall(out_stall),
		.red_out(red_out), .green_out(green_out), .blue_out(blue_out),
		.frame_last(frame_last)
	);

	// Items waiting for transfer and blurred pixels waiting to come out
	blur_item_t  pixel_q[$];
	blur_pixel_t blurred_q[$];
	int          mismatches;
	int          cycles;
	int          items_sent;
	bit          quiet;

	// Predictor state: its own line store and raw window, plus frame counters
	logic [23:0] row_store [RING_ROWS*MAX_WIDTH];
	logic [23:0] raw_win [WIN_LEN];
	int          reg_w, reg_h, reg_r;
	int          lat_w, lat_h, lat_r;
	int          in_col, in_row, out_col, out_row;
	bit          frame_on;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 6000000) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic logic [23:0] mean_rgb(int sr, int sg, int sb, int cnt);
		if (cnt == 0)
			cnt = 1;
		return {8'((sr / cnt) & 255), 8'((sg / cnt) & 255), 8'((sb / cnt) & 255)};
	endfunction

	// Horizontal window mean of column c in row y, written into the line store
	function automatic void store_row_mean(int c, int y);
		int lo, hi, sr, sg, sb;
		lo = (c > lat_r) ? c - lat_r : 0;
		hi = (c + lat_r > lat_w - 1) ? lat_w - 1 : c + lat_r;
		sr = 0; sg = 0; sb = 0;
		for (int k = lo; k <= hi; k++) begin
			sr += raw_win[k % WIN_LEN][23:16];
			sg += raw_win[k % WIN_LEN][15:8];
			sb += raw_win[k % WIN_LEN][7:0];
		end
		row_store[(y % RING_ROWS) * MAX_WIDTH + (c % MAX_WIDTH)] = mean_rgb(sr, sg, sb, hi - lo + 1);
	endfunction

	function automatic rgb_t column_mean(int c, int oy);
		int lo, hi, sr, sg, sb;
		logic [23:0] p;
		lo = (oy > lat_r) ? oy - lat_r : 0;
		hi = (oy + lat_r > lat_h - 1) ? lat_h - 1 : oy + lat_r;
		sr = 0; sg = 0; sb = 0;
		for (int k = lo; k <= hi; k++) begin
			p = row_store[(k % RING_ROWS) * MAX_WIDTH + (c % MAX_WIDTH)];
			sr += p[23:16];
			sg += p[15:8];
			sb += p[7:0];
		end
		return rgb_t'(mean_rgb(sr, sg, sb, hi - lo + 1));
	endfunction

	function automatic void emit_blurred(logic last);
		blur_pixel_t e;
		e.px = column_mean(out_col, out_row);
		e.last = last;
		blurred_q.push_back(e);
		out_col++;
		if (out_col >= lat_w) begin
			out_col = 0;
			out_row++;
		end
	endfunction

	// Advance the predictor by one item and queue it for the driver
	function automatic void send_item(op_t op, rgb_t px);
		blur_item_t it;
		int x, y, c;
		logic last;
		it.op = op;
		it.px = px;
		pixel_q.push_back(it);
		items_sent++;
		if (op == OP_PIXEL) begin
			if (!frame_on) begin
				lat_w = (reg_w < 1) ? 1 : (reg_w > MAX_WIDTH ? MAX_WIDTH : reg_w);
				lat_h = (reg_h < 1) ? 1 : (reg_h > MAX_HEIGHT ? MAX_HEIGHT : reg_h);
				lat_r = (reg_r > MAX_RADIUS) ? MAX_RADIUS : reg_r;
				in_col = 0; in_row = 0; out_col = 0; out_row = 0;
				frame_on = 1;
			end
			// drop surplus pixels past the frame end
			if (in_row >= lat_h)
				return;
			x = in_col;
			y = in_row;
			raw_win[x % WIN_LEN] = px;
			if (x >= lat_r)
				store_row_mean(x - lat_r, y);
			if (x + 1 >= lat_w) begin
				for (c = (lat_w > lat_r) ? lat_w - lat_r : 0; c < lat_w; c++)
					store_row_mean(c, y);
				in_col = 0;
				in_row++;
			end else
				in_col++;
			if (out_row + lat_r + 1 <= y)
				emit_blurred(1'b0);
		end else begin
			// drain too early or while idle: nothing comes out
			if (!frame_on || in_row < lat_h || out_row >= lat_h)
				return;
			last = (out_col + 1 >= lat_w && out_row + 1 >= lat_h);
			emit_blurred(last);
			if (last)
				frame_on = 0;
		end
	endfunction

	function automatic rgb_t any_rgb();
		return rgb_t'(24'($urandom));
	endfunction

	// Driver: hold a stalled item, otherwise offer the next one or idle a burst
	int send_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			operation <= OP_PIXEL;
			red_in    <= '0;
			green_in  <= '0;
			blue_in   <= '0;
			send_gap  = 0;
		end else begin
			if (in_valid && !in_stall)
				void'(pixel_q.pop_front());
			if (!(in_valid && in_stall)) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pixel_q.size() > 0) begin
					in_valid  <= 1'b1;
					operation <= pixel_q[0].op;
					red_in    <= pixel_q[0].px.r;
					green_in  <= pixel_q[0].px.g;
					blue_in   <= pixel_q[0].px.b;
					if (!quiet && $urandom_range(0, 11) == 0)
						send_gap = $urandom_range(1, 14);
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// Monitor: compare each transfer with the oldest blurred pixel, and drive stall
	int stall_left;
	always @(posedge clk or negedge arst_n) begin
		blur_pixel_t e;
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (blurred_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected pixel %h%h%h last %b", red_out, green_out,
							blue_out, frame_last);
				end else begin
					e = blurred_q.pop_front();
					if (red_out !== e.px.r || green_out !== e.px.g || blue_out !== e.px.b ||
							frame_last !== e.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display("pixel mismatch: exp %h %h %h last %b, got %h %h %h last %b",
								e.px.r, e.px.g, e.px.b, e.last,
								red_out, green_out, blue_out, frame_last);
					end
				end
			end
			// one long hold-off so the block fills up and stalls its input
			if (cycles == 30000)
				stall_left = 1500;
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(0, 13);
				out_stall <= 1'b1;
			end else
				out_stall <= 1'b0;
		end
	end

	// Wait until the block has drained, then let the pipeline settle
	task automatic wait_idle();
		while (pixel_q.size() != 0 || blurred_q.size() != 0)
			@(posedge clk);
		repeat (250) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, int val);
		@(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= CFG_W'(val);
		case (idx)
			REG_WIDTH:  reg_w = val & 12'hFFF;
			REG_HEIGHT: reg_h = val & 12'hFFF;
			default:    reg_r = val & 4'hF;
		endcase
	endtask

	// One complete frame; noisy frames add early drains and surplus pixels
	task automatic run_frame(int w, int h, int r, bit noisy, int fill);
		wait_idle();
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		write_reg(REG_RADIUS, r);
		@(posedge clk);
		wr_en <= 1'b0;
		@(negedge clk);
		if (noisy && $urandom_range(0, 2) == 0)
			send_item(OP_DRAIN, any_rgb());
		send_item(OP_PIXEL, fill < 0 ? any_rgb() : rgb_t'(24'(fill)));
		while (in_row < lat_h) begin
			if (noisy && $urandom_range(0, 15) == 0)
				send_item(OP_DRAIN, any_rgb());
			send_item(OP_PIXEL, fill < 0 ? any_rgb() : rgb_t'(24'(fill)));
		end
		while (frame_on) begin
			if (noisy && $urandom_range(0, 7) == 0)
				send_item(OP_PIXEL, any_rgb());
			else
				send_item(OP_DRAIN, any_rgb());
		end
	endtask

	initial begin
		int start_items;
		arst_n     = 1'b0;
		wr_en      = 1'b0;
		wr_index   = REG_WIDTH;
		wr_data    = '0;
		mismatches = 0;
		cycles     = 0;
		items_sent = 0;
		quiet      = 0;
		frame_on   = 0;
		reg_w = 1920; reg_h = 1080; reg_r = 12;
		repeat (4) @(posedge clk);
		arst_n = 1'b1;

		// Directed: tiny frames, channel extremes, saturation and stray items
		run_frame(1, 1, 0, 0, 24'hFFFFFF);
		run_frame(3, 3, 1, 0, 24'h000000);
		run_frame(2, 2, 1, 1, -1);
		run_frame(0, 0, 15, 0, 24'hFF00FF);
		run_frame(4, 3, 12, 1, -1);
		@(negedge clk);
		send_item(OP_DRAIN, rgb_t'(24'hFFFFFF));

		// Extremes of the frame size, both saturating
		run_frame(4095, 1, 15, 0, -1);
		run_frame(0, 2048, 12, 0, -1);

		// Random frames, mostly small
		start_items = items_sent;
		while (items_sent - start_items < 650) begin
			if ($urandom_range(0, 9) == 0)
				run_frame($urandom_range(13, 40), $urandom_range(1, 6), $urandom_range(0, 15),
					1, -1);
			else
				run_frame($urandom_range(1, 9), $urandom_range(1, 9), $urandom_range(0, 13),
					$urandom_range(0, 1), -1);
		end

		// Closing stretch without idling
		wait_idle();
		quiet = 1;
		run_frame(6, 5, 2, 1, -1);
		run_frame(5, 7, 12, 0, -1);
		wait_idle();
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule

// File: separable_box_blur.f
+incdir+rtl
rtl/sbb_pkg.sv
rtl/sbb_ram.sv
rtl/sbb_div.sv
rtl/separable_box_blur.sv
rtl/sbb_check.sv
sim/tb.sv
